FILE: hw/rtl/dcsb_pkg.sv
// dcsb_pkg: field widths, codes and the cell record of the dirty-cell screen buffer
// depends on nothing; imported by dirty_cell_screen_buffer
package dcsb_pkg;

	localparam int ACTION_W   = 2;
	localparam int COL_W      = 8;
	localparam int ROW_W      = 6;
	localparam int GLYPH_W    = 21;
	localparam int COLOR_W    = 16;
	localparam int CFG_COLS_W = 9;
	localparam int CFG_ROWS_W = 7;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int PROD_W     = 16;

	// action codes
	localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_SCAN  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

	// result kinds
	localparam logic KIND_CELL    = 1'b0;
	localparam logic KIND_PRESENT = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEFCOL  = 2'd2;

	// configuration reset values
	localparam logic [CFG_COLS_W-1:0] COLUMNS_RST = 9'd80;
	localparam logic [CFG_ROWS_W-1:0] ROWS_RST    = 7'd24;
	localparam logic [COLOR_W-1:0]    DEFCOL_RST  = 16'd0;

	localparam logic [GLYPH_W-1:0] SPACE_GLYPH = 21'h20;

	typedef struct packed {
		logic [GLYPH_W-1:0] glyph;
		logic [COLOR_W-1:0] fore;
		logic [COLOR_W-1:0] back;
	} cell_t;

endpackage

FILE: hw/rtl/dirty_cell_screen_buffer.sv
// dirty_cell_screen_buffer: text screen store with per-cell dirty tracking and scan-out
// depends on dcsb_pkg; holds the cell memory and the dirty-mark memory
// sequence: a write commits in ST_EXEC; a scan issues its memory read in ST_EXEC and emits
//   in ST_READ, a present marker after a cell result in the cycle after it; a clear walks the
//   cell memory one entry a cycle through its single write port. the memories are read
//   through a register. results are strobed for one cycle each and cannot be stalled.
// reset: a clearing pass fills every cell with a space in colour 0,
//   dirty, with busy high; configuration writes are taken during it
module dirty_cell_screen_buffer #(
	parameter int MAX_COLS   = 256,
	parameter int MAX_ROWS   = 64,
	parameter int CELL_COUNT = 16384
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write port
	input  logic                            cfg_we,
	input  logic [dcsb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dcsb_pkg::CFG_DATA_W-1:0] cfg_data,
	// command side
	input  logic                            start,
	output logic                            busy,
	input  logic [dcsb_pkg::ACTION_W-1:0]   action,
	input  logic [dcsb_pkg::COL_W-1:0]      col,
	input  logic [dcsb_pkg::ROW_W-1:0]      row,
	input  logic [dcsb_pkg::GLYPH_W-1:0]    glyph,
	input  logic [dcsb_pkg::COLOR_W-1:0]    fore,
	input  logic [dcsb_pkg::COLOR_W-1:0]    back,
	// result side
	output logic                            strobe,
	output logic                            kind,
	output logic [dcsb_pkg::COL_W-1:0]      out_col,
	output logic [dcsb_pkg::ROW_W-1:0]      out_row,
	output logic [dcsb_pkg::GLYPH_W-1:0]    out_glyph,
	output logic [dcsb_pkg::COLOR_W-1:0]    out_fore,
	output logic [dcsb_pkg::COLOR_W-1:0]    out_back,
	output logic                            last
);
	import dcsb_pkg::*;

	// memory address width and a linear index width wide enough for both
	// the screen product and the store bound
	localparam int AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
	localparam int IW = ((AW > PROD_W) ? AW : PROD_W) + 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(CELL_COUNT - 1);
	localparam logic [IW-1:0] CELL_LIMIT = IW'(CELL_COUNT);

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EXEC  = 3'd1; // write commit or memory read issue
	localparam logic [2:0] ST_READ  = 3'd2; // read data back, emit and clean
	localparam logic [2:0] ST_PRES  = 3'd3; // present marker after a cell result
	localparam logic [2:0] ST_SWEEP = 3'd4; // clearing pass over the whole store

	// memories
	cell_t cell_mem  [CELL_COUNT];
	logic  dirty_mem [CELL_COUNT];

	// configuration registers
	logic [CFG_COLS_W-1:0] columns_q;
	logic [CFG_ROWS_W-1:0] rows_q;
	logic [COLOR_W-1:0]    defcol_q;

	// control state
	logic [2:0]            state_q;
	logic [AW-1:0]         sweep_q;
	logic [COLOR_W-1:0]    fill_q;
	logic [CFG_COLS_W-1:0] scan_col_q;
	logic [CFG_ROWS_W-1:0] scan_row_q;
	logic                  any_q;
	logic                  strobe_q;

	// item registers captured at the transfer
	logic [ACTION_W-1:0]   act_s1;
	logic [AW-1:0]         idx_s1;
	logic                  hit_s1;
	logic                  final_s1;
	logic [CFG_COLS_W-1:0] col_s1;
	logic [CFG_ROWS_W-1:0] row_s1;
	cell_t                 data_s1;

	// memory read data
	cell_t rd_cell_q;
	logic  rd_dirty_q;

	// result registers
	logic               kind_q;
	logic [COL_W-1:0]   ocol_q;
	logic [ROW_W-1:0]   orow_q;
	cell_t              ocell_q;
	logic               last_q;

	// effective geometry
	logic [CFG_COLS_W-1:0] nc;
	logic [CFG_ROWS_W-1:0] nr;
	logic [IW-1:0]         total;

	// scan pointer, pulled back to the origin when it lies off the screen
	logic                  off_screen;
	logic [CFG_COLS_W-1:0] adj_col;
	logic [CFG_ROWS_W-1:0] adj_row;
	logic                  at_row_end;
	logic                  at_final;

	// shared index multiplier operands
	logic [IW-1:0] mul_row;
	logic [IW-1:0] mul_col;
	logic [IW-1:0] lin_idx;
	logic          write_hit;
	logic          scan_hit;

	logic accept;
	logic emit_cell;
	logic emit_pres;

	// memory write port controls
	logic          mem_we;
	logic          dirty_we;
	logic [AW-1:0] wr_addr;
	cell_t         wr_cell;
	logic          wr_dirty;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	// clamp zero and oversized geometry
	always_comb begin
		if (columns_q == '0) begin
			nc = CFG_COLS_W'(1);
		end else if (32'(columns_q) > MAX_COLS) begin
			nc = CFG_COLS_W'(MAX_COLS);
		end else begin
			nc = columns_q;
		end
		if (rows_q == '0) begin
			nr = CFG_ROWS_W'(1);
		end else if (32'(rows_q) > MAX_ROWS) begin
			nr = CFG_ROWS_W'(MAX_ROWS);
		end else begin
			nr = rows_q;
		end
	end

	assign total = IW'(nc) * IW'(nr);

	assign off_screen = (scan_col_q >= nc) || (scan_row_q >= nr);
	assign adj_col    = off_screen ? '0 : scan_col_q;
	assign adj_row    = off_screen ? '0 : scan_row_q;
	assign at_row_end = (adj_col == nc - CFG_COLS_W'(1));
	assign at_final   = at_row_end && (adj_row == nr - CFG_ROWS_W'(1));

	// one multiplier: write position or scan position, row times width plus column
	always_comb begin
		if (action == ACT_SCAN) begin
			mul_row = IW'(adj_row);
			mul_col = IW'(adj_col);
		end else begin
			mul_row = IW'(row);
			mul_col = IW'(col);
		end
	end

	assign lin_idx   = mul_row * IW'(nc) + mul_col;
	assign write_hit = (lin_idx < total) && (lin_idx < CELL_LIMIT);
	assign scan_hit  = (lin_idx < CELL_LIMIT);

	// a cell goes out when the scanned entry exists and is dirty
	assign emit_cell = (state_q == ST_READ) && hit_s1 && rd_dirty_q;
	// the present marker closes a pass in which something went out
	assign emit_pres = (state_q == ST_READ) && final_s1 && (any_q || emit_cell);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= COLUMNS_RST;
			rows_q    <= ROWS_RST;
			defcol_q  <= DEFCOL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COLUMNS: columns_q <= cfg_data[CFG_COLS_W-1:0];
				REG_ROWS:    rows_q    <= cfg_data[CFG_ROWS_W-1:0];
				REG_DEFCOL:  defcol_q  <= cfg_data[COLOR_W-1:0];
				default: begin
					// index past the register list is ignored
				end
			endcase
		end
	end

	// sequencer, scan pointer and pass flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_SWEEP;
			sweep_q    <= '0;
			fill_q     <= '0;
			scan_col_q <= '0;
			scan_row_q <= '0;
			any_q      <= 1'b0;
			act_s1     <= ACT_WRITE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						act_s1 <= action;
						priority if (action == ACT_CLEAR) begin
							state_q <= ST_SWEEP;
							sweep_q <= '0;
							fill_q  <= defcol_q;
						end else if (action == ACT_SCAN) begin
							state_q <= ST_EXEC;
							// step the pointer past the cell being scanned
							if (at_final) begin
								scan_col_q <= '0;
								scan_row_q <= '0;
							end else if (at_row_end) begin
								scan_col_q <= '0;
								scan_row_q <= adj_row + CFG_ROWS_W'(1);
							end else begin
								scan_col_q <= adj_col + CFG_COLS_W'(1);
								scan_row_q <= adj_row;
							end
						end else if (action == ACT_WRITE) begin
							state_q <= ST_EXEC;
						end else begin
							// unused action: nothing to do
							state_q <= ST_IDLE;
						end
					end
				end
				ST_EXEC: begin
					state_q <= (act_s1 == ACT_SCAN) ? ST_READ : ST_IDLE;
				end
				ST_READ: begin
					if (final_s1) begin
						any_q <= 1'b0;
					end else if (emit_cell) begin
						any_q <= 1'b1;
					end
					state_q <= (emit_cell && emit_pres) ? ST_PRES : ST_IDLE;
				end
				ST_PRES: begin
					state_q <= ST_IDLE;
				end
				ST_SWEEP: begin
					if (sweep_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end else begin
						sweep_q <= sweep_q + AW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item payload captured at the transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1        <= lin_idx[AW-1:0];
			hit_s1        <= (action == ACT_SCAN) ? scan_hit : write_hit;
			final_s1      <= at_final;
			col_s1        <= adj_col;
			row_s1        <= adj_row;
			data_s1.glyph <= glyph;
			data_s1.fore  <= fore;
			data_s1.back  <= back;
		end
	end

	// memory write port: the sweep, a committed write, or a dirty mark cleaned by a scan
	always_comb begin
		mem_we   = 1'b0;
		dirty_we = 1'b0;
		wr_addr  = idx_s1;
		wr_cell  = data_s1;
		wr_dirty = 1'b1;
		unique case (state_q)
			ST_SWEEP: begin
				mem_we        = 1'b1;
				dirty_we      = 1'b1;
				wr_addr       = sweep_q;
				wr_cell.glyph = SPACE_GLYPH;
				wr_cell.fore  = fill_q;
				wr_cell.back  = fill_q;
			end
			ST_EXEC: begin
				mem_we   = (act_s1 == ACT_WRITE) && hit_s1;
				dirty_we = (act_s1 == ACT_WRITE) && hit_s1;
			end
			ST_READ: begin
				dirty_we = emit_cell;
				wr_dirty = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// cell memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			cell_mem[wr_addr] <= wr_cell;
		end
		rd_cell_q <= cell_mem[idx_s1];
	end

	// dirty-mark memory
	always_ff @(posedge clk) begin
		if (dirty_we) begin
			dirty_mem[wr_addr] <= wr_dirty;
		end
		rd_dirty_q <= dirty_mem[idx_s1];
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit_cell || emit_pres || (state_q == ST_PRES);
		end
	end

	// result payload: the cell first, the present marker on its own or in the cycle after it
	always_ff @(posedge clk) begin
		if (emit_cell) begin
			kind_q  <= KIND_CELL;
			ocol_q  <= col_s1[COL_W-1:0];
			orow_q  <= row_s1[ROW_W-1:0];
			ocell_q <= rd_cell_q;
			last_q  <= !emit_pres;
		end else if (emit_pres || (state_q == ST_PRES)) begin
			kind_q  <= KIND_PRESENT;
			ocol_q  <= '0;
			orow_q  <= '0;
			ocell_q <= '0;
			last_q  <= 1'b1;
		end
	end

	assign strobe    = strobe_q;
	assign kind      = kind_q;
	assign out_col   = ocol_q;
	assign out_row   = orow_q;
	assign out_glyph = ocell_q.glyph;
	assign out_fore  = ocell_q.fore;
	assign out_back  = ocell_q.back;
	assign last      = last_q;

	// a present marker always ends the results of its scan
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (kind == KIND_PRESENT) |-> last)
		else $error("present marker without last");

	// a cell result that is not last is followed at once by the present marker
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe && (kind == KIND_PRESENT))
		else $error("missing present marker after cell result");

	// results only come out of the read-back or present steps
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> ($past(state_q) == ST_READ) || ($past(state_q) == ST_PRES))
		else $error("result strobe outside scan read-back");

	// the clearing pass walks the store one entry a cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP) && (sweep_q != LAST_ADDR) |=>
		(state_q == ST_SWEEP) && (sweep_q == $past(sweep_q) + AW'(1)))
		else $error("clearing pass skipped an entry");

endmodule
